FILE: sv/assert_macros.svh
// Assertion macros used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tgfsr_pkg.sv
// ----------------------------------------------------------------------------
// tgfsr_pkg
// Shared constants and types of the twisted GFSR random word generator.
// ----------------------------------------------------------------------------
package tgfsr_pkg;
    localparam int unsigned TableDepthDef = 624;
    localparam int unsigned TapOffsetDef  = 397;
    localparam logic [31:0] SeedReset     = 32'd4357;
    localparam logic [31:0] LcgMult       = 32'd69069;
    localparam logic [31:0] TwistMatrix   = 32'h9908B0DF;
    localparam logic [31:0] TemperB       = 32'h9D2C5680;
    localparam logic [31:0] TemperC       = 32'hEFC60000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic fill_start;   // load seed word, index 0
        logic fill_step;    // write current word, advance LCG
        logic in_cap;       // capture the request fields
        logic rd_sel_nxt;   // read address is the successor of word i
        logic rd_sel_tap;   // read address is the tap word
        logic cap_a;        // capture read data into word i reg
        logic cap_b;        // capture read data into next reg
        logic cap_t;        // capture tap reg
        logic twist_wr;     // write twisted word at i
        logic twist_adv;    // advance twist index
        logic twist_start;  // reset twist indexes
        logic draw_rd;      // read word at read index
        logic draw_cap;     // capture drawn word, temper, bump index
        logic div_start;    // start remainder unit
        logic out_load;     // load result register
        logic idx_zero;     // read index to 0 (after twist)
    } t_cmd;

    // Status from the datapath.
    typedef struct packed {
        logic fill_last;
        logic twist_last;
        logic need_twist;
        logic div_busy;
    } t_sts;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TemperB);
        y = y ^ ((y << 15) & TemperC);
        y = y ^ (y >> 18);
        return y;
    endfunction
endpackage

FILE: sv/tgfsr_ram.sv
// ----------------------------------------------------------------------------
// tgfsr_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tgfsr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 624
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: sv/tgfsr_div.sv
// ----------------------------------------------------------------------------
// tgfsr_div
// Radix-2 restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tgfsr_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [30:0] i_divisor,
    output logic        o_busy,
    output logic [31:0] o_rem
);
    logic [31:0] r_num;
    logic [31:0] r_rem;
    logic [30:0] r_div;
    logic [5:0]  r_cnt;
    logic [32:0] w_shift;
    logic [32:0] w_diff;

    assign w_shift = {r_rem, r_num[31]};
    assign w_diff  = w_shift - {2'b00, r_div};

    // Shift in one dividend bit per cycle and subtract when it fits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 6'd32;
            r_num <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != 6'd0) begin
            r_cnt <= r_cnt - 6'd1;
            r_num <= {r_num[30:0], 1'b0};
            r_rem <= w_diff[32] ? w_shift[31:0] : w_diff[31:0];
        end
    end

    assign o_busy = (r_cnt != 6'd0);
    assign o_rem  = r_rem;
endmodule

FILE: sv/tgfsr_datapath.sv
// ----------------------------------------------------------------------------
// tgfsr_datapath
// Word table, seed recurrence, twist, tempering and result register.
// ----------------------------------------------------------------------------
module tgfsr_datapath #(
    parameter int unsigned TABLE_DEPTH = tgfsr_pkg::TableDepthDef,
    parameter int unsigned TAP_OFFSET  = tgfsr_pkg::TapOffsetDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [31:0]      i_seed,
    input  tgfsr_pkg::t_cmd  i_cmd,
    output tgfsr_pkg::t_sts  o_sts,
    input  logic             i_reduce,
    input  logic [30:0]      i_modulus,
    output logic [31:0]      o_value
);
    import tgfsr_pkg::*;

    localparam int unsigned AW   = $clog2(TABLE_DEPTH);
    localparam int unsigned TAP0 = TAP_OFFSET % TABLE_DEPTH;
    localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

    logic [AW-1:0] r_i, r_nxt, r_tap, r_rd_idx;
    logic          r_rd_over;
    logic [31:0]   r_lcg, r_a, r_b, r_t, r_word;
    logic          r_reduce, r_zero;
    logic [30:0]   r_mod;
    logic          w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    logic [31:0]   w_wdata, w_rdata, w_y, w_rem, w_tempered;
    logic          w_busy;

    function automatic logic [AW-1:0] inc(input logic [AW-1:0] v);
        return (v == LAST) ? '0 : v + AW'(1);
    endfunction

    // Top bit of word i joined with the low 31 bits of its successor; the tap word enters the write data.
    assign w_y = {r_a[31], r_b[30:0]};

    // Tempered form of the word being drawn.
    assign w_tempered = temper(w_rdata);

    // RAM port selection.
    always_comb begin
        w_we    = i_cmd.fill_step | i_cmd.twist_wr;
        w_waddr = r_i;
        w_wdata = i_cmd.fill_step ? r_lcg
                : (r_t ^ (w_y >> 1) ^ (w_y[0] ? TwistMatrix : 32'd0));
        if (i_cmd.draw_rd) begin
            w_raddr = r_rd_idx;
        end else if (i_cmd.rd_sel_tap) begin
            w_raddr = r_tap;
        end else if (i_cmd.rd_sel_nxt) begin
            w_raddr = r_nxt;
        end else begin
            w_raddr = r_i;
        end
    end

    tgfsr_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    tgfsr_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.div_start),
        .i_dividend(w_tempered),
        .i_divisor (r_mod),
        .o_busy    (w_busy),
        .o_rem     (w_rem)
    );

    // Index, recurrence and operand registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx  <= AW'(1);
            r_rd_over <= 1'b0;
        end else begin
            if (i_cmd.fill_start) begin
                r_rd_idx  <= AW'(1);
                r_rd_over <= 1'b0;
            end else if (i_cmd.idx_zero) begin
                r_rd_idx  <= '0;
                r_rd_over <= 1'b0;
            end else if (i_cmd.draw_cap) begin
                r_rd_over <= (r_rd_idx == LAST);
                r_rd_idx  <= inc(r_rd_idx);
            end
        end
        // Fill and twist walk the table with the same write index.
        if (i_cmd.fill_start) begin
            r_i   <= '0;
            r_lcg <= i_seed;
        end else if (i_cmd.fill_step) begin
            r_i   <= r_i + AW'(1);
            r_lcg <= r_lcg * LcgMult;
        end else if (i_cmd.twist_start) begin
            r_i   <= '0;
            r_nxt <= AW'(1);
            r_tap <= AW'(TAP0);
        end else if (i_cmd.twist_adv) begin
            r_i   <= inc(r_i);
            r_nxt <= inc(r_nxt);
            r_tap <= inc(r_tap);
        end
        if (i_cmd.cap_a) r_a <= w_rdata;
        if (i_cmd.cap_b) r_b <= w_rdata;
        if (i_cmd.cap_t) r_t <= w_rdata;
        if (i_cmd.in_cap) begin
            r_reduce <= i_reduce;
            r_mod    <= i_modulus;
            r_zero   <= (i_modulus == 31'd0);
        end
        if (i_cmd.draw_cap) begin
            r_word <= w_tempered;
        end
        if (i_cmd.out_load) begin
            o_value <= !r_reduce ? r_word : (r_zero ? 32'd0 : w_rem);
        end
    end

    assign o_sts.fill_last  = (r_i == LAST);
    assign o_sts.twist_last = (r_i == LAST);
    assign o_sts.need_twist = r_rd_over;
    assign o_sts.div_busy   = w_busy;
endmodule

FILE: sv/tgfsr_ctrl.sv
// ----------------------------------------------------------------------------
// tgfsr_ctrl
// Sequencer for table fill, twist pass and one draw per request.
// ----------------------------------------------------------------------------
module tgfsr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  tgfsr_pkg::t_sts i_sts,
    output tgfsr_pkg::t_cmd o_cmd
);
    import tgfsr_pkg::*;

    typedef enum logic [12:0] {
        S_FILL0 = 13'b0000000000001,
        S_FILL  = 13'b0000000000010,
        S_IDLE  = 13'b0000000000100,
        S_TW0   = 13'b0000000001000,
        S_TWA   = 13'b0000000010000,
        S_TWB   = 13'b0000000100000,
        S_TWT   = 13'b0000001000000,
        S_TWW   = 13'b0000010000000,
        S_TWX   = 13'b0000100000000,
        S_DRD   = 13'b0001000000000,
        S_DCAP  = 13'b0010000000000,
        S_DIV   = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_in_acc;

    assign o_cfg_ready = (r_state == S_IDLE) && !r_out_valid && !i_in_valid;
    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign w_in_acc    = i_in_valid && o_in_ready;

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        case (r_state)
            S_FILL0: begin
                o_cmd.fill_start = 1'b1;
                n_state = S_FILL;
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.fill_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_cfg_valid && o_cfg_ready) begin
                    n_state = S_FILL0;
                end else if (w_in_acc) begin
                    o_cmd.in_cap = 1'b1;
                    n_state = i_sts.need_twist ? S_TW0 : S_DRD;
                end
            end
            S_TW0: begin
                o_cmd.twist_start = 1'b1;
                n_state = S_TWA;
            end
            S_TWA: begin
                // Read of word i is issued here.
                n_state = S_TWB;
            end
            S_TWB: begin
                o_cmd.cap_a      = 1'b1;
                o_cmd.rd_sel_nxt = 1'b1;
                n_state = S_TWT;
            end
            S_TWT: begin
                o_cmd.cap_b      = 1'b1;
                o_cmd.rd_sel_tap = 1'b1;
                n_state = S_TWW;
            end
            S_TWW: begin
                o_cmd.cap_t = 1'b1;
                n_state = S_TWX;
            end
            S_TWX: begin
                // Write the twisted word i and move on.
                o_cmd.twist_wr  = 1'b1;
                o_cmd.twist_adv = 1'b1;
                if (i_sts.twist_last) begin
                    o_cmd.idx_zero = 1'b1;
                    n_state = S_DRD;
                end else begin
                    n_state = S_TWA;
                end
            end
            S_DRD: begin
                o_cmd.draw_rd = 1'b1;
                n_state = S_DCAP;
            end
            S_DCAP: begin
                o_cmd.draw_cap  = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (!i_sts.div_busy) n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_FILL0;
        endcase
    end

    // State and output valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

FILE: sv/twisted_gfsr_random_generator.sv
// ----------------------------------------------------------------------------
// twisted_gfsr_random_generator
// Table-based tempered random word generator with optional modulo reduction.
// ----------------------------------------------------------------------------
// Usage: each transfer on the s_axis channel requests one word; tdata holds
// reduce in bit 0 and modulus in bits 31:1. One result leaves on m_axis as a
// 32-bit value. A seed transfer on the cfg channel refills the table.
// Each request reads its word from the RAM, captures and tempers it, runs
// it through the one-bit-per-cycle remainder unit (run on every draw) and
// loads the output register. Once the draw index passes the last word
// (TABLE_DEPTH-1 draws after a fill, TABLE_DEPTH after a twist), the next
// draw first regenerates the table, reading each word, its successor and
// the tap word through the single RAM read port and writing back the twist.
// Reset: the table is refilled from seed 4357, one word per cycle, and no
// request or seed is accepted meanwhile. Seed writes refill it the same way
// and are accepted only when idle.
// Stall: the result is held in the output register until taken; a new
// request is accepted only once the previous result has left.
// ----------------------------------------------------------------------------
module twisted_gfsr_random_generator #(
    parameter int unsigned TABLE_DEPTH = tgfsr_pkg::TableDepthDef,
    parameter int unsigned TAP_OFFSET  = tgfsr_pkg::TapOffsetDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // reduce [0], modulus [31:1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // value [31:0]
);
    import tgfsr_pkg::*;
    `include "assert_macros.svh"

    t_cmd w_cmd;
    t_sts w_sts;
    logic [31:0] r_seed;

    // Seed register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= SeedReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_seed <= i_cfg_data;
        end
    end

    tgfsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tgfsr_datapath #(.TABLE_DEPTH(TABLE_DEPTH), .TAP_OFFSET(TAP_OFFSET)) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_seed   (r_seed),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_reduce (s_axis_tdata[0]),
        .i_modulus(s_axis_tdata[31:1]),
        .o_value  (m_axis_tdata)
    );

    `ASSERT_IMPL(a_no_accept_busy, i_clk, i_rst_n, s_axis_tready, !m_axis_tvalid,
        "request accepted while a result is pending")
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
    `ASSERT_IMPL(a_cfg_excl, i_clk, i_rst_n, o_cfg_ready, s_axis_tready,
        "seed write outside idle")
endmodule
